@@ hdl/krcp_pkg.sv @@
// Shared types and constants for the key range chunk planner.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package krcp_pkg;

  localparam int CHUNK_W    = 32;  // chunk size register
  localparam int WIDE_W     = 48;  // chunk numbers, offsets, byte counts
  localparam int LEN_W      = 31;  // request length, segment offset/length
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int MUL_HALF   = 24;  // chunk number is multiplied in two halves
  localparam int DIV_CNT_W  = 6;   // counts the 48 quotient bits

  localparam logic [WIDE_W-1:0] INT_MAX = 48'h0000_7FFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHUNK_SIZE  = 3'd0,
    REG_KEY_TOTAL   = 3'd1,
    REG_ENC_ALLOWED = 3'd2,
    REG_REVOKED     = 3'd3,
    REG_BASE_CHUNK  = 3'd4,
    REG_BASE_OFFSET = 3'd5,
    REG_BASE_USED   = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_OK            = 4'd0,
    ST_ZERO_LENGTH   = 4'd1,
    ST_DECRYPT_ONLY  = 4'd2,
    ST_REVOKED       = 4'd3,
    ST_TOO_SMALL     = 4'd4,
    ST_EXHAUSTED     = 4'd5,
    ST_PAST_END      = 4'd6,
    ST_OFFSET_BEYOND = 4'd7,
    ST_TOO_MANY_SEGS = 4'd8,
    ST_SEG_OVERFLOW  = 4'd9
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL_LO,
    S_MUL_HI,
    S_DIV,
    S_PLAN,
    S_ERR,
    S_MONO,
    S_SEG
  } fsm_state_t;

  typedef struct packed {
    logic                action;
    logic [LEN_W-1:0]    request_length;
    logic [WIDE_W-1:0]   global_offset;
  } in_req_t;

  typedef struct packed {
    status_t             status;
    logic [WIDE_W-1:0]   segment_chunk;
    logic [LEN_W-1:0]    segment_offset;
    logic [LEN_W-1:0]    segment_length;
    logic [WIDE_W-1:0]   start_offset;
    logic                last;
  } out_res_t;

  // controller -> datapath
  typedef struct packed {
    logic req_load;
    logic check_load;
    logic mul_lo;
    logic mul_hi;
    logic div_start;
    logic div_take;
    logic plan_load;
    logic emit_err;
    logic emit_mono;
    logic emit_seg;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    status_t early_st;
    status_t plan_st;
    logic    chunked;
    logic    is_enc;
    logic    div_done;
    logic    out_free;
    logic    seg_last;
  } dp_sts_t;

endpackage

@@ hdl/krcp_div.sv @@
// Restoring divider, 48-bit dividend by 32-bit divisor, one quotient bit per cycle.
// Depends on krcp_pkg.
module krcp_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [krcp_pkg::WIDE_W-1:0]   dividend,
  input  logic [krcp_pkg::CHUNK_W-1:0]  divisor,
  output logic                          done,
  output logic [krcp_pkg::WIDE_W-1:0]   quotient,
  output logic [krcp_pkg::CHUNK_W-1:0]  remainder
);

  logic                              busy_r;
  logic                              done_r;
  logic [krcp_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [krcp_pkg::CHUNK_W-1:0]      rem_r;
  logic [krcp_pkg::WIDE_W-1:0]       quo_r;
  logic [krcp_pkg::CHUNK_W:0]        trial;
  logic                              fits;
  logic [krcp_pkg::CHUNK_W-1:0]      rem_nxt;

  assign trial   = {rem_r, quo_r[krcp_pkg::WIDE_W-1]};
  assign fits    = trial >= {1'b0, divisor};
  assign rem_nxt = fits ? krcp_pkg::CHUNK_W'(trial - {1'b0, divisor})
                        : trial[krcp_pkg::CHUNK_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == krcp_pkg::DIV_CNT_W'(krcp_pkg::WIDE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[krcp_pkg::WIDE_W-2:0], fits};
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

@@ hdl/krcp_ctrl.sv @@
// Controller state machine of the key range chunk planner.
// Depends on krcp_pkg; drives krcp_dp through ctrl_cmd_t, reads dp_sts_t.
module krcp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  krcp_pkg::dp_sts_t    sts,
  output krcp_pkg::ctrl_cmd_t  cmd
);

  krcp_pkg::fsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= krcp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      krcp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_nxt    = krcp_pkg::S_CHECK;
        end
      end
      krcp_pkg::S_CHECK: begin
        cmd.check_load = 1'b1;
        if (sts.early_st != krcp_pkg::ST_OK) begin
          state_nxt = krcp_pkg::S_ERR;
        end else if (!sts.chunked) begin
          state_nxt = krcp_pkg::S_PLAN;
        end else if (sts.is_enc) begin
          state_nxt = krcp_pkg::S_MUL_LO;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = krcp_pkg::S_DIV;
        end
      end
      krcp_pkg::S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = krcp_pkg::S_MUL_HI;
      end
      krcp_pkg::S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = krcp_pkg::S_PLAN;
      end
      krcp_pkg::S_DIV: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = krcp_pkg::S_PLAN;
        end
      end
      krcp_pkg::S_PLAN: begin
        cmd.plan_load = 1'b1;
        if (sts.plan_st != krcp_pkg::ST_OK) begin
          state_nxt = krcp_pkg::S_ERR;
        end else if (sts.chunked) begin
          state_nxt = krcp_pkg::S_SEG;
        end else begin
          state_nxt = krcp_pkg::S_MONO;
        end
      end
      krcp_pkg::S_ERR: begin
        if (sts.out_free) begin
          cmd.emit_err = 1'b1;
          state_nxt    = krcp_pkg::S_IDLE;
        end
      end
      krcp_pkg::S_MONO: begin
        if (sts.out_free) begin
          cmd.emit_mono = 1'b1;
          state_nxt     = krcp_pkg::S_IDLE;
        end
      end
      krcp_pkg::S_SEG: begin
        if (sts.out_free) begin
          cmd.emit_seg = 1'b1;
          if (sts.seg_last) begin
            state_nxt = krcp_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = krcp_pkg::S_IDLE;
      end
    endcase
  end

  // divider result is only ever awaited in the divide state
  assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> state_r == krcp_pkg::S_DIV)
    else $error("divider finished outside the divide state");

endmodule

@@ hdl/krcp_dp.sv @@
// Datapath of the key range chunk planner: config and position registers, checks,
// start-offset multiplier, segment walker and output register. Depends on krcp_pkg, krcp_div.
module krcp_dp #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  krcp_pkg::in_req_t                 in_data,
  input  logic                              cfg_we,
  input  logic [krcp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [krcp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  krcp_pkg::ctrl_cmd_t               cmd,
  output krcp_pkg::dp_sts_t                 sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output krcp_pkg::out_res_t                out_data
);

  localparam int LIMF_W = $clog2(MAX_SEGMENTS);
  localparam int LIM_W  = krcp_pkg::CHUNK_W + LIMF_W;
  localparam logic [LIMF_W-1:0] SPILL_CHUNKS = LIMF_W'(MAX_SEGMENTS - 2);

  localparam int CW = krcp_pkg::CHUNK_W;
  localparam int WW = krcp_pkg::WIDE_W;
  localparam int LW = krcp_pkg::LEN_W;
  localparam int MH = krcp_pkg::MUL_HALF;

  // configuration and persistent position
  logic [CW-1:0]  cs_r;
  logic [WW-1:0]  total_r;
  logic           enc_ok_r;
  logic           revoked_r;
  logic [WW-1:0]  pos_chunk_r;
  logic [WW-1:0]  pos_off_r;
  logic [WW-1:0]  used_r;

  // per-request working registers
  krcp_pkg::in_req_t  req_r;
  logic [WW-1:0]      ch_r;
  logic [WW-1:0]      off_r;
  logic [LW-1:0]      rem_r;
  logic [WW-1:0]      start_r;
  logic [LIM_W-1:0]   limit_r;
  krcp_pkg::status_t  err_r;

  logic               out_valid_r;
  krcp_pkg::out_res_t out_data_r;

  // ---------------- checks ----------------
  logic [WW:0]        used_sum;
  logic [WW:0]        goff_sum;
  logic [LW-1:0]      len;
  krcp_pkg::status_t  early_st;
  krcp_pkg::status_t  plan_st;
  logic [CW-1:0]      room;
  logic               over_room;
  logic [LW-1:0]      spill;
  logic               too_many;
  logic               chunked;

  assign len      = req_r.request_length;
  assign chunked  = cs_r != '0;
  assign used_sum = {1'b0, used_r} + (WW + 1)'(len);
  assign goff_sum = {1'b0, req_r.global_offset} + (WW + 1)'(len);

  always_comb begin
    if (len == '0) begin
      early_st = krcp_pkg::ST_ZERO_LENGTH;
    end else if (req_r.action && !enc_ok_r) begin
      early_st = krcp_pkg::ST_DECRYPT_ONLY;
    end else if (revoked_r) begin
      early_st = krcp_pkg::ST_REVOKED;
    end else if (total_r < WW'(len)) begin
      early_st = krcp_pkg::ST_TOO_SMALL;
    end else if (req_r.action && used_sum > {1'b0, total_r}) begin
      early_st = krcp_pkg::ST_EXHAUSTED;
    end else if (!req_r.action && goff_sum > {1'b0, total_r}) begin
      early_st = krcp_pkg::ST_PAST_END;
    end else begin
      early_st = krcp_pkg::ST_OK;
    end
  end

  // room is meaningful once off_r <= chunk size, which is checked first
  assign room      = cs_r - off_r[CW-1:0];
  assign over_room = {1'b0, len} > room;
  assign spill     = len - room[LW-1:0];
  assign too_many  = over_room && (LIM_W'(spill) > limit_r);

  always_comb begin
    if (chunked && off_r > WW'(cs_r)) begin
      plan_st = krcp_pkg::ST_OFFSET_BEYOND;
    end else if (chunked && too_many) begin
      plan_st = krcp_pkg::ST_TOO_MANY_SEGS;
    end else if (off_r > krcp_pkg::INT_MAX) begin
      plan_st = krcp_pkg::ST_SEG_OVERFLOW;
    end else begin
      plan_st = krcp_pkg::ST_OK;
    end
  end

  // ---------------- start offset multiplier ----------------
  logic [MH-1:0]     mul_a;
  logic [MH+CW-1:0]  mul_prod;
  logic [WW-1:0]     mul_add;

  assign mul_a    = cmd.mul_hi ? ch_r[WW-1:MH] : ch_r[MH-1:0];
  assign mul_prod = mul_a * cs_r;
  // only the low half of the upper product lands below bit 48
  assign mul_add  = cmd.mul_hi ? {mul_prod[MH-1:0], {MH{1'b0}}} : mul_prod[WW-1:0];

  // ---------------- divider ----------------
  logic           div_done;
  logic [WW-1:0]  div_quo;
  logic [CW-1:0]  div_rem;

  krcp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (req_r.global_offset),
    .divisor   (cs_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // ---------------- segment walker ----------------
  logic [LW-1:0]  take;
  logic [CW-1:0]  off_sum;
  logic           wrap;
  logic [WW-1:0]  ch_nxt;
  logic [WW-1:0]  off_nxt;
  logic [LW-1:0]  rem_nxt;
  logic           seg_last;

  assign take     = ({1'b0, rem_r} > room) ? room[LW-1:0] : rem_r;
  assign off_sum  = off_r[CW-1:0] + CW'(take);
  assign wrap     = off_sum >= cs_r;
  assign ch_nxt   = wrap ? ch_r + 1'b1 : ch_r;
  assign off_nxt  = wrap ? '0 : WW'(off_sum);
  assign rem_nxt  = rem_r - take;
  assign seg_last = rem_r == take;

  // ---------------- registers ----------------
  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r        <= '0;
      total_r     <= '0;
      enc_ok_r    <= 1'b0;
      revoked_r   <= 1'b0;
      pos_chunk_r <= '0;
      pos_off_r   <= '0;
      used_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        krcp_pkg::REG_CHUNK_SIZE:  cs_r        <= cfg_data[CW-1:0];
        krcp_pkg::REG_KEY_TOTAL:   total_r     <= cfg_data[WW-1:0];
        krcp_pkg::REG_ENC_ALLOWED: enc_ok_r    <= cfg_data[0];
        krcp_pkg::REG_REVOKED:     revoked_r   <= cfg_data[0];
        krcp_pkg::REG_BASE_CHUNK:  pos_chunk_r <= cfg_data[WW-1:0];
        krcp_pkg::REG_BASE_OFFSET: pos_off_r   <= cfg_data[WW-1:0];
        krcp_pkg::REG_BASE_USED:   used_r      <= cfg_data[WW-1:0];
        default: ;
      endcase
    end else if (cmd.emit_mono && req_r.action) begin
      pos_off_r <= off_r + WW'(len);
      used_r    <= used_r + WW'(len);
    end else if (cmd.emit_seg && seg_last && req_r.action) begin
      pos_chunk_r <= ch_nxt;
      pos_off_r   <= off_nxt;
      used_r      <= used_r + WW'(len);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_r <= in_data;
    end
    if (cmd.check_load) begin
      ch_r    <= pos_chunk_r;
      off_r   <= req_r.action ? pos_off_r : req_r.global_offset;
      start_r <= req_r.action ? pos_off_r : req_r.global_offset;
      rem_r   <= len;
      limit_r <= LIM_W'(cs_r) * LIM_W'(SPILL_CHUNKS);
      err_r   <= early_st;
    end
    if (cmd.mul_lo || cmd.mul_hi) begin
      start_r <= start_r + mul_add;
    end
    if (cmd.div_take) begin
      ch_r  <= div_quo;
      off_r <= WW'(div_rem);
    end
    if (cmd.plan_load) begin
      err_r <= plan_st;
    end
    if (cmd.emit_seg) begin
      ch_r  <= ch_nxt;
      off_r <= off_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_err || cmd.emit_mono || cmd.emit_seg) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      out_data_r <= '{status: err_r, segment_chunk: '0, segment_offset: '0,
                      segment_length: '0, start_offset: '0, last: 1'b1};
    end else if (cmd.emit_mono) begin
      out_data_r.status         <= krcp_pkg::ST_OK;
      out_data_r.segment_chunk  <= ch_r;
      out_data_r.segment_offset <= off_r[LW-1:0];
      out_data_r.segment_length <= len;
      out_data_r.start_offset   <= start_r;
      out_data_r.last           <= 1'b1;
    end else if (cmd.emit_seg) begin
      out_data_r.status         <= krcp_pkg::ST_OK;
      out_data_r.segment_chunk  <= ch_r;
      out_data_r.segment_offset <= off_r[LW-1:0];
      out_data_r.segment_length <= take;
      out_data_r.start_offset   <= start_r;
      out_data_r.last           <= seg_last;
    end
  end

  assign sts.early_st = early_st;
  assign sts.plan_st  = plan_st;
  assign sts.chunked  = chunked;
  assign sts.is_enc   = req_r.action;
  assign sts.div_done = div_done;
  assign sts.out_free = out_free;
  assign sts.seg_last = seg_last;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a segment is never emitted past the end of the request
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_seg |-> rem_r != '0 || room == '0)
    else $error("segment emitted with nothing left to take");

endmodule

@@ hdl/key_range_chunk_planner_top.sv @@
// Top level of the key range chunk planner: controller plus datapath.
// Depends on krcp_pkg, krcp_ctrl, krcp_dp (which holds krcp_div).
//
//  port group  | dir     | handshake          | carries
//  in_*        | in      | in_valid/in_ready  | krcp_pkg::in_req_t request
//  out_*       | out     | out_valid/out_ready| krcp_pkg::out_res_t segment or error
//  cfg_*       | in      | cfg_we, no wait    | register index 0..6, 48-bit data
//
//  One request at a time; in_ready is high only while the controller idles.
//  Flag or size error: the check state, then the error state loads the output
//  register. An error found while planning comes out where the first segment
//  would. Monolithic (chunk size 0): check, plan, emit. Chunked encrypt: check,
//  then two passes of a 24x32 multiplier build the start offset, plan, then one
//  segment per cycle. Chunked decrypt: check, the 48-step one-bit-per-cycle
//  divider that splits the offset, plan, then one segment per cycle.
//  A full output register holds the walk; out_ready low stalls it in place.
//  Synchronous active-low reset clears config, position, used count, state.
module key_range_chunk_planner_top #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  krcp_pkg::in_req_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output krcp_pkg::out_res_t                out_data,
  input  logic                              cfg_we,
  input  logic [krcp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [krcp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  krcp_pkg::ctrl_cmd_t cmd;
  krcp_pkg::dp_sts_t   sts;

  // sequencing: idle, check, multiply or divide, plan, emit
  krcp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // all arithmetic, state and the output register
  krcp_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a request is worked on alone
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // error results are single and closed
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != krcp_pkg::ST_OK |->
      out_data.last && out_data.segment_length == '0)
    else $error("error result not final or carries a length");

  // only ok results may continue a walk
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.status == krcp_pkg::ST_OK)
    else $error("non-final result with error status");

  // back at idle, any pending result closes its request
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_data.last)
    else $error("idle with an open segment walk");

endmodule

@@ tb/tb_key_range_chunk_planner_top.sv @@
// Testbench for key_range_chunk_planner_top: directed and random key-range requests,
// checked segment by segment against an in-bench planner model.
// Depends on krcp_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module tb_key_range_chunk_planner_top;

  localparam int          CLK_PERIOD     = 10;
  localparam int          PLAN_MAX_SEGS  = 64;
  localparam int          STALL_LIMIT    = 4000;  // cycles with no handshake or register write at all
  localparam int          SETTLE_CYCLES  = 64;    // time left for a late or extra result to show up
  localparam int          PHASE_REQUESTS = 30;
  localparam logic        ACT_DECRYPT    = 1'b0;
  localparam logic        ACT_ENCRYPT    = 1'b1;
  localparam logic [krcp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [63:0] WIDE_MASK      = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] LEN_MAX        = 64'h7FFF_FFFF;
  localparam logic [63:0] INT_MAX_64     = 64'h7FFF_FFFF;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  krcp_pkg::in_req_t               in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  krcp_pkg::out_res_t              out_data;
  logic                            cfg_we    = 1'b0;
  logic [krcp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [krcp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // planner model state: register copies plus the recorded key position
  logic [krcp_pkg::CHUNK_W-1:0] chunk_bytes;
  logic [krcp_pkg::WIDE_W-1:0]  key_bytes;
  logic                         enc_ok;
  logic                         revoked_flag;
  logic [krcp_pkg::WIDE_W-1:0]  cur_chunk;
  logic [krcp_pkg::WIDE_W-1:0]  cur_offset;
  logic [krcp_pkg::WIDE_W-1:0]  used_count;

  krcp_pkg::out_res_t expected_segments[$];
  int       fail_count     = 0;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;
  int       quiet_cycles   = 0;

  key_range_chunk_planner_top #(
    .MAX_SEGMENTS(PLAN_MAX_SEGS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Planner model
  // ---------------------------------------------------------------------------
  function automatic void push_result(krcp_pkg::status_t st, logic [63:0] ch,
                                      logic [63:0] off, logic [63:0] len,
                                      logic [63:0] start, logic last);
    krcp_pkg::out_res_t res;
    res.status         = st;
    res.segment_chunk  = ch[krcp_pkg::WIDE_W-1:0];
    res.segment_offset = off[krcp_pkg::LEN_W-1:0];
    res.segment_length = len[krcp_pkg::LEN_W-1:0];
    res.start_offset   = start[krcp_pkg::WIDE_W-1:0];
    res.last           = last;
    expected_segments.push_back(res);
  endfunction

  // Works out every segment (or the single error) one accepted request yields.
  function automatic void plan_request(krcp_pkg::in_req_t r);
    logic [63:0] len, goff, cs, ch, off, start, rem, take, room, spill, needed, sum;
    logic        enc;
    krcp_pkg::status_t st;
    int          n;
    enc  = (r.action == ACT_ENCRYPT);
    len  = 64'(r.request_length);
    goff = 64'(r.global_offset);
    cs   = 64'(chunk_bytes);
    st   = krcp_pkg::ST_OK;
    if (len == 0)                                     st = krcp_pkg::ST_ZERO_LENGTH;
    else if (enc && !enc_ok)                          st = krcp_pkg::ST_DECRYPT_ONLY;
    else if (revoked_flag)                            st = krcp_pkg::ST_REVOKED;
    else if (64'(key_bytes) < len)                    st = krcp_pkg::ST_TOO_SMALL;
    else if (enc && 64'(used_count) + len > 64'(key_bytes))
      st = krcp_pkg::ST_EXHAUSTED;
    else if (!enc && goff + len > 64'(key_bytes))     st = krcp_pkg::ST_PAST_END;
    if (st != krcp_pkg::ST_OK) begin
      push_result(st, 0, 0, 0, 0, 1'b1);
      return;
    end

    if (enc) begin
      ch  = 64'(cur_chunk);
      off = 64'(cur_offset);
    end else if (cs != 0) begin
      ch  = goff / cs;
      off = goff % cs;
    end else begin
      ch  = 64'(cur_chunk);
      off = goff;
    end
    // product may run past 64 bits; only the low 48 matter
    start = (cs != 0) ? ((ch * cs + off) & WIDE_MASK) : off;

    // monolithic key: one segment, the chunk number never moves
    if (cs == 0) begin
      if (off > INT_MAX_64) begin
        push_result(krcp_pkg::ST_SEG_OVERFLOW, 0, 0, 0, 0, 1'b1);
      end else begin
        push_result(krcp_pkg::ST_OK, ch, off, len, start, 1'b1);
        if (enc) begin
          sum        = off + len;
          cur_offset = sum[krcp_pkg::WIDE_W-1:0];
          sum        = 64'(used_count) + len;
          used_count = sum[krcp_pkg::WIDE_W-1:0];
        end
      end
      return;
    end

    if (off > cs) begin
      push_result(krcp_pkg::ST_OFFSET_BEYOND, 0, 0, 0, 0, 1'b1);
      return;
    end
    // segment count plus one spare must fit the segment table
    room   = cs - off;
    needed = 1;
    if (len > room) begin
      spill  = len - room;
      needed = needed + spill / cs + ((spill % cs != 0) ? 1 : 0);
    end
    needed = needed + 1;
    if (needed > 64'(PLAN_MAX_SEGS)) begin
      push_result(krcp_pkg::ST_TOO_MANY_SEGS, 0, 0, 0, 0, 1'b1);
      return;
    end
    if (off > INT_MAX_64) begin
      push_result(krcp_pkg::ST_SEG_OVERFLOW, 0, 0, 0, 0, 1'b1);
      return;
    end

    // walk the chunks; an offset equal to the chunk size gives an empty first piece
    rem = len;
    n   = 0;
    while (rem != 0 && n < PLAN_MAX_SEGS - 1) begin
      room = cs - off;
      take = (rem > room) ? room : rem;
      rem  = rem - take;
      push_result(krcp_pkg::ST_OK, ch, off, take, start, rem == 0);
      n++;
      off = off + take;
      if (off >= cs) begin
        ch  = (ch + 1) & WIDE_MASK;
        off = 0;
      end
    end
    if (enc) begin
      cur_chunk  = ch[krcp_pkg::WIDE_W-1:0];
      cur_offset = off[krcp_pkg::WIDE_W-1:0];
      sum        = 64'(used_count) + len;
      used_count = sum[krcp_pkg::WIDE_W-1:0];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [47:0] rand48();
    logic [31:0] hi;
    hi = $urandom;
    return {hi[15:0], $urandom};
  endfunction

  function automatic logic [63:0] rand_upto(logic [63:0] bound);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw % (bound + 64'd1);
  endfunction

  function automatic krcp_pkg::in_req_t make_req(logic act, logic [63:0] len,
                                                 logic [63:0] goff);
    krcp_pkg::in_req_t r;
    r.action         = act;
    r.request_length = len[krcp_pkg::LEN_W-1:0];
    r.global_offset  = goff[krcp_pkg::WIDE_W-1:0];
    return r;
  endfunction

  // One request: optional idle gap, then hold valid until the block takes it.
  // The leading edge keeps the drop of valid and the next raise in separate steps.
  task automatic send_request(krcp_pkg::in_req_t r);
    @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    plan_request(r);
    in_valid <= 1'b0;
  endtask

  // Register write; the model copy changes at the same edge as the block's.
  task automatic write_reg(logic [krcp_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[krcp_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      krcp_pkg::REG_CHUNK_SIZE:  chunk_bytes  = val[krcp_pkg::CHUNK_W-1:0];
      krcp_pkg::REG_KEY_TOTAL:   key_bytes    = val[krcp_pkg::WIDE_W-1:0];
      krcp_pkg::REG_ENC_ALLOWED: enc_ok       = val[0];
      krcp_pkg::REG_REVOKED:     revoked_flag = val[0];
      krcp_pkg::REG_BASE_CHUNK:  cur_chunk    = val[krcp_pkg::WIDE_W-1:0];
      krcp_pkg::REG_BASE_OFFSET: cur_offset   = val[krcp_pkg::WIDE_W-1:0];
      krcp_pkg::REG_BASE_USED:   used_count   = val[krcp_pkg::WIDE_W-1:0];
      default: ;
    endcase
  endtask

  // All results in, and the controller back in idle (in_ready high).
  task automatic wait_idle();
    while (expected_segments.size() != 0) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and receiver back-pressure
  // ---------------------------------------------------------------------------
  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    krcp_pkg::out_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_segments.size() == 0) begin
        $error("unexpected result: status %0d chunk %0h", out_data.status,
               out_data.segment_chunk);
        fail_count++;
      end else begin
        want = expected_segments.pop_front();
        check_field("status", 64'(want.status), 64'(out_data.status));
        check_field("segment_chunk", 64'(want.segment_chunk), 64'(out_data.segment_chunk));
        check_field("segment_offset", 64'(want.segment_offset),
                    64'(out_data.segment_offset));
        check_field("segment_length", 64'(want.segment_length),
                    64'(out_data.segment_length));
        check_field("start_offset", 64'(want.start_offset), 64'(out_data.start_offset));
        check_field("last", 64'(want.last), 64'(out_data.last));
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Flag and size checks, starting from reset values (everything zero).
  task automatic test_flag_errors();
    send_request(make_req(ACT_DECRYPT, 0, 0));
    send_request(make_req(ACT_ENCRYPT, 0, WIDE_MASK));
    send_request(make_req(ACT_ENCRYPT, 5, 0));         // encrypt not allowed
    send_request(make_req(ACT_DECRYPT, 1, 0));         // total is zero
    wait_idle();
    write_reg(REG_UNUSED, WIDE_MASK);                   // no such register
    write_reg(krcp_pkg::REG_REVOKED, 1);
    write_reg(krcp_pkg::REG_KEY_TOTAL, WIDE_MASK);
    write_reg(krcp_pkg::REG_ENC_ALLOWED, 1);
    send_request(make_req(ACT_DECRYPT, 1, 0));
    send_request(make_req(ACT_ENCRYPT, LEN_MAX, 0));
    wait_idle();
    write_reg(krcp_pkg::REG_REVOKED, 0);
  endtask

  // Chunk size zero: one segment, offset limited to INT_MAX.
  task automatic test_monolithic();
    write_reg(krcp_pkg::REG_BASE_CHUNK, 64'(rand48()));
    write_reg(krcp_pkg::REG_BASE_OFFSET, 0);
    write_reg(krcp_pkg::REG_BASE_USED, 0);
    send_request(make_req(ACT_ENCRYPT, LEN_MAX, 0));
    send_request(make_req(ACT_ENCRYPT, 1, 0));          // starts exactly at INT_MAX
    send_request(make_req(ACT_ENCRYPT, 1, 0));          // now past INT_MAX
    send_request(make_req(ACT_DECRYPT, 1, INT_MAX_64));
    send_request(make_req(ACT_DECRYPT, 1, INT_MAX_64 + 1));
    send_request(make_req(ACT_DECRYPT, 1, WIDE_MASK));  // past the end
    wait_idle();
    write_reg(krcp_pkg::REG_KEY_TOTAL, 100);
    send_request(make_req(ACT_DECRYPT, 101, 0));
    send_request(make_req(ACT_DECRYPT, 100, 0));        // exactly the whole key
    wait_idle();
    write_reg(krcp_pkg::REG_KEY_TOTAL, WIDE_MASK);
    write_reg(krcp_pkg::REG_BASE_USED, WIDE_MASK);
    send_request(make_req(ACT_ENCRYPT, 1, 0));          // key used up
    wait_idle();
    write_reg(krcp_pkg::REG_BASE_USED, 0);
  endtask

  // Small chunks: chunk number wrap, offset equal to the chunk size, offset beyond.
  task automatic test_chunk_walk();
    write_reg(krcp_pkg::REG_CHUNK_SIZE, 16);
    write_reg(krcp_pkg::REG_BASE_CHUNK, WIDE_MASK);
    write_reg(krcp_pkg::REG_BASE_OFFSET, 14);
    send_request(make_req(ACT_ENCRYPT, 5, 0));
    wait_idle();
    write_reg(krcp_pkg::REG_BASE_OFFSET, 16);
    send_request(make_req(ACT_ENCRYPT, 3, 0));
    wait_idle();
    write_reg(krcp_pkg::REG_BASE_OFFSET, WIDE_MASK);
    send_request(make_req(ACT_ENCRYPT, 1, 0));
    send_request(make_req(ACT_DECRYPT, 40, 37));
    wait_idle();
    write_reg(krcp_pkg::REG_CHUNK_SIZE, 64'hFFFF_FFFF);
    send_request(make_req(ACT_DECRYPT, 10, WIDE_MASK - 10));
    send_request(make_req(ACT_DECRYPT, 7, INT_MAX_64));
  endtask

  // One-byte chunks: the longest legal walk and the first count over the limit.
  task automatic test_segment_limits();
    wait_idle();
    write_reg(krcp_pkg::REG_CHUNK_SIZE, 1);
    write_reg(krcp_pkg::REG_BASE_OFFSET, 0);
    send_request(make_req(ACT_DECRYPT, 63, 5));
    send_request(make_req(ACT_DECRYPT, 64, 5));
    send_request(make_req(ACT_ENCRYPT, 62, 0));
  endtask

  // One random phase: fresh settings, then mostly well-formed requests.
  task automatic random_phase(int cfg_kind);
    logic [63:0] cs, total, len_cap, len, goff_cap, base_cap;
    krcp_pkg::in_req_t r;
    int          i;
    wait_idle();
    case (cfg_kind)
      0:       cs = 0;
      1:       cs = 64'($urandom_range(64, 1));
      2:       cs = 64'($urandom_range(32'h0010_0000, 1));
      default: cs = 64'($urandom_range(32'hFFFF_FFFF, 32'h0400_0000));
    endcase
    total    = (cfg_kind == 2) ? (64'(rand48()) >> 8) + 64'h8000_0000 : WIDE_MASK;
    base_cap = (cs == 0) ? (INT_MAX_64 >> 1) : ((cs - 1 > INT_MAX_64) ? INT_MAX_64 : cs - 1);
    len_cap  = (cs == 0 || cs * 60 > LEN_MAX) ? LEN_MAX : cs * 60;
    write_reg(krcp_pkg::REG_CHUNK_SIZE, cs);
    write_reg(krcp_pkg::REG_KEY_TOTAL, total);
    write_reg(krcp_pkg::REG_ENC_ALLOWED, 64'($urandom_range(3) != 0));
    write_reg(krcp_pkg::REG_BASE_CHUNK, 64'(rand48()));
    write_reg(krcp_pkg::REG_BASE_OFFSET, rand_upto(base_cap));
    write_reg(krcp_pkg::REG_BASE_USED, rand_upto(total >> 1));
    for (i = 0; i < PHASE_REQUESTS; i++) begin
      if ($urandom_range(99) < 12) begin
        // noise: any field value at all
        len = ($urandom_range(15) == 0) ? 64'd0 : 64'($urandom) & LEN_MAX;
        r   = make_req(1'($urandom_range(1)), len, 64'(rand48()));
      end else begin
        len = 1 + rand_upto(len_cap - 1);
        if (cs == 0 && $urandom_range(7) != 0) len = 1 + rand_upto(64'h000F_FFFF);
        goff_cap = total - len;
        if (cs == 0 && goff_cap > INT_MAX_64) goff_cap = INT_MAX_64;
        r = make_req(1'($urandom_range(1)), len, rand_upto(goff_cap));
      end
      send_request(r);
    end
  endtask

  task automatic test_random_traffic();
    int p;
    for (p = 0; p < 8; p++) begin
      case ((p + p / 4) % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      random_phase(p % 4);
    end
  endtask

  initial begin
    chunk_bytes  = '0;
    key_bytes    = '0;
    enc_ok       = 1'b0;
    revoked_flag = 1'b0;
    cur_chunk    = '0;
    cur_offset   = '0;
    used_count   = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_flag_errors();
    test_monolithic();
    test_chunk_walk();
    test_segment_limits();
    test_random_traffic();

    // drain, then give a late or extra result time to show up
    while (expected_segments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
